// ===== rtl/aob_pkg.sv =====
// shared types and helpers for the alpha-over pixel blender
package aob_pkg;

  // channels per pixel: red, green, blue, alpha
  localparam int LANES     = 4;
  localparam int LANE_ALPHA = 3;

  // which source the result of one pixel comes from
  typedef enum logic {
    PATH_BLEND  = 1'b0,
    PATH_BYPASS = 1'b1
  } path_e;

  // round a bit count up to whole bytes
  function automatic int pad_to_bytes(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

// ===== rtl/alpha_over_blend_pixel.sv =====
// alpha-over compositing of two straight-alpha rgba pixels, fully pipelined
//
//  channel   | direction | carries
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | under pixel in the low half, over pixel in the high half
//  m_axis    | out       | composited pixel, one transaction per input
//  cfg       | in        | blend_enable, write-only
//
// one pixel enters per cycle while no stall at m_axis backs up the pipe
// the divider gives one quotient bit per stage, after a multiply stage,
// a numerator/denominator stage and a dividend stage
// every stage has its own valid bit and ready, so bubbles close up and a
// stall at m_axis holds each pixel in place without loss or repeat
// rst_ni clears the valid bits and blend_enable; payload is not reset
module alpha_over_blend_pixel #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  // under_red, under_green, under_blue, under_alpha,
  // over_red, over_green, over_blue, over_alpha
  input  logic [8*CHANNEL_BITS-1:0]                      s_axis_tdata,
  input  logic                                           s_axis_tvalid,
  output logic                                           s_axis_tready,
  // out_red, out_green, out_blue, out_alpha, zero pad
  output logic [aob_pkg::pad_to_bytes(4*CHANNEL_BITS)-1:0] m_axis_tdata,
  output logic                                           m_axis_tvalid,
  input  logic                                           m_axis_tready,
  input  logic                                           cfg_we_i,
  input  logic                                           cfg_wdata_i
);

  localparam int N      = CHANNEL_BITS;
  localparam int L      = aob_pkg::LANES;
  localparam int PIX_W  = L * N;
  localparam int OUT_W  = aob_pkg::pad_to_bytes(PIX_W);
  localparam int DW     = 3 * N + 1;   // dividend 2*num + den
  localparam int VW     = 2 * N + 1;   // divisor 2*den
  // stage numbering
  localparam int ST_MUL  = 0;
  localparam int ST_SUM  = 1;
  localparam int ST_PREP = 2;
  localparam int ST_DIV0 = 3;
  localparam int NS      = ST_DIV0 + N;
  localparam logic [N-1:0] MAX = '1;
  localparam logic [2*N-1:0] HALF = {{N{1'b0}}, 1'b1, {(N-1){1'b0}}};

  // ---------------------------------------------------------------
  // config register
  // ---------------------------------------------------------------
  logic blend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q <= 1'b0;
    end else if (cfg_we_i) begin
      blend_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------
  // valid bits and per-stage ready chain
  // ---------------------------------------------------------------
  logic [NS-1:0] vld_q;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // input unpack and bypass decision
  // ---------------------------------------------------------------
  logic [N-1:0]   a0, a1;
  logic [2:0][N-1:0] c0, c1;
  aob_pkg::path_e path_d;
  logic [PIX_W-1:0] pix_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c0[i] = s_axis_tdata[i*N +: N];
      c1[i] = s_axis_tdata[(L+i)*N +: N];
    end
    a0 = s_axis_tdata[aob_pkg::LANE_ALPHA*N +: N];
    a1 = s_axis_tdata[(L+aob_pkg::LANE_ALPHA)*N +: N];
    // blend off shows the over pixel, transparent over shows the under one
    path_d = (!blend_q || (a1 == '0)) ? aob_pkg::PATH_BYPASS : aob_pkg::PATH_BLEND;
    pix_d  = !blend_q ? s_axis_tdata[2*PIX_W-1:PIX_W] : s_axis_tdata[PIX_W-1:0];
  end

  // bypass path travels with every stage
  aob_pkg::path_e   path_q [NS];
  logic [PIX_W-1:0] pix_q  [NS];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      path_q[0] <= path_d;
      pix_q[0]  <= pix_d;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        path_q[k] <= path_q[k-1];
        pix_q[k]  <= pix_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 0: the narrow products
  // ---------------------------------------------------------------
  logic [2*N-1:0]      paa_q;    // a0*a1
  logic [2:0][2*N-1:0] p0_q;     // c0*a0
  logic [2:0][2*N-1:0] p1_q;     // c1*a1
  logic [N-1:0]        inv1_q;   // max - a1
  logic [N:0]          asum_q;   // a0 + a1

  always_ff @(posedge clk_i) begin
    if (rdy[ST_MUL]) begin
      paa_q  <= a0 * a1;
      inv1_q <= MAX - a1;
      asum_q <= {1'b0, a0} + {1'b0, a1};
      for (int i = 0; i < 3; i++) begin
        p0_q[i] <= c0[i] * a0;
        p1_q[i] <= c1[i] * a1;
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 1: den = max*(a0+a1) - a0*a1, num = c0*a0*(max-a1) + max*c1*a1
  // ---------------------------------------------------------------
  logic [2*N:0]        den_full;
  logic [2*N-1:0]      den_q;
  logic [2:0][3*N-1:0] num_d, num_q;

  always_comb begin
    // times max is a shift and a subtract
    den_full = {asum_q, {N{1'b0}}} - (2*N+1)'(asum_q) - (2*N+1)'(paa_q);
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (3*N)'(p0_q[i]) * (3*N)'(inv1_q)
               + (3*N)'({p1_q[i], {N{1'b0}}}) - (3*N)'(p1_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_SUM]) begin
      den_q <= den_full[2*N-1:0];
      num_q <= num_d;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: round-to-nearest dividend and divisor per color lane
  // q = floor((2*num + den) / (2*den))
  // alpha = round(den / max); max is 2^n - 1, so with t = den + max/2
  // rounded up, the quotient is (t + (t >> n)) >> n for any den up to max^2
  // ---------------------------------------------------------------
  logic [2:0][DW-1:0] dvd_q;
  logic [2:0][VW-1:0] dvs_q;
  logic [2*N-1:0]     alf_t, alf_u;
  logic [N-1:0]       alf_q;

  always_comb begin
    alf_t = den_q + HALF;
    alf_u = alf_t + {{N{1'b0}}, alf_t[2*N-1:N]};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_PREP]) begin
      for (int i = 0; i < 3; i++) begin
        dvd_q[i] <= {num_q[i], 1'b0} + DW'(den_q);
        dvs_q[i] <= {den_q, 1'b0};
      end
      alf_q <= alf_u[2*N-1:N];
    end
  end

  // ---------------------------------------------------------------
  // restoring divider, one quotient bit per stage, msb first
  // the quotient never exceeds max, so it fits the channel width;
  // alpha rides alongside
  // ---------------------------------------------------------------
  logic [2:0][DW-1:0] rem_q   [N];
  logic [2:0][VW-1:0] div_q   [N];
  logic [2:0][N-1:0]  quo_q   [N];
  logic [N-1:0]       alf_p_q [N];

  for (genvar gj = 0; gj < N; gj++) begin : g_div
    localparam int SH = N - 1 - gj;
    logic [2:0][DW-1:0] rem_in, rem_d;
    logic [2:0][VW-1:0] div_in;
    logic [2:0][N-1:0]  quo_in, quo_d;
    logic [2:0][DW-1:0] vsh;
    logic [N-1:0]       alf_in;

    if (gj == 0) begin : g_first
      assign rem_in = dvd_q;
      assign div_in = dvs_q;
      assign quo_in = '0;
      assign alf_in = alf_q;
    end else begin : g_next
      assign rem_in = rem_q[gj-1];
      assign div_in = div_q[gj-1];
      assign quo_in = quo_q[gj-1];
      assign alf_in = alf_p_q[gj-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        vsh[l] = DW'(div_in[l]) << SH;
        if (rem_in[l] >= vsh[l]) begin
          rem_d[l] = rem_in[l] - vsh[l];
          quo_d[l] = {quo_in[l][N-2:0], 1'b1};
        end else begin
          rem_d[l] = rem_in[l];
          quo_d[l] = {quo_in[l][N-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[ST_DIV0+gj]) begin
        rem_q[gj]   <= rem_d;
        div_q[gj]   <= div_in;
        quo_q[gj]   <= quo_d;
        alf_p_q[gj] <= alf_in;
      end
    end
  end

  // ---------------------------------------------------------------
  // output: quotients or the bypassed pixel
  // ---------------------------------------------------------------
  logic [PIX_W-1:0] out_pix;

  assign out_pix = (path_q[NS-1] == aob_pkg::PATH_BYPASS) ? pix_q[NS-1]
                                                         : {alf_p_q[N-1], quo_q[N-1]};

  assign m_axis_tdata  = OUT_W'(out_pix);
  assign m_axis_tvalid = vld_q[NS-1];

endmodule

// ===== rtl/aob_checker.sv =====
// port-level checks for the alpha-over pixel blender and its bind
module aob_checker #(
  parameter int CHANNEL_BITS = 8
) (
  input logic                                             clk_i,
  input logic                                             rst_ni,
  input logic                                             s_axis_tready,
  input logic [aob_pkg::pad_to_bytes(4*CHANNEL_BITS)-1:0] m_axis_tdata,
  input logic                                             m_axis_tvalid,
  input logic                                             m_axis_tready
);

  // a downstream that takes data never backs up the input
  a_ready_through : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  // an empty output register means the whole pipe can advance
  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no pending output");

  // a stalled output transaction holds its pixel
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed during stall");

endmodule

bind alpha_over_blend_pixel aob_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_aob_checker (.*);
